/* rtl/tgbfs_pkg.sv */
// shared constants, types and register codes for the threshold graph bfs block
// no dependencies; used by every module under rtl

package tgbfs_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int VAL_W         = 16;
    localparam int NODE_W        = 6;
    localparam int CNT_W         = 7;
    localparam int THR_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_THRESHOLD  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_RUN  = 1'b1
    } t_action;

    // control broadcast to every cell of the ring
    typedef struct packed {
        logic shift;
        logic clr_vis;
    } t_cell_ctrl;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] comp;
        logic              is_root;
        logic              last;
    } t_result;

endpackage

/* rtl/threshold_graph_bfs_components_core.sv */
// channel   direction  accepted when              payload
// s stream  in         i_s_tvalid & o_s_tready    tuser action, tdata index/value
// m stream  out        o_m_tvalid & i_m_tready    tdata node/parent/comp, tuser root
// cfg write in         i_cfg_we                   i_cfg_addr, i_cfg_data
//
// in a run each dequeued node rotates the value ring once, one pair per cycle unless
// the output stalls. reset is synchronous and clears control state and the visited
// marks; node values are not cleared. a stalled output holds the ring where a
// neighbour waits to be sent.
// depends on tgbfs_pkg, tgbfs_cell, tgbfs_queue

module threshold_graph_bfs_components_core #(
    parameter int MAX_NODES = tgbfs_pkg::MAX_NODES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tgbfs_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [tgbfs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [5:0] node_index, [21:6] node_value, [23:22] zero
    input  logic [tgbfs_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // [0] action
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [5:0] node, [11:6] parent, [17:12] component, [23:18] zero
    output logic [tgbfs_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // [0] is_root
    output logic                                 o_m_tuser,
    output logic                                 o_m_tlast
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int VW = tgbfs_pkg::VAL_W;
    localparam int NW = tgbfs_pkg::NODE_W;
    localparam int QW = IW + VW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROOT  = 5'b00010,
        S_FETCH = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [tgbfs_pkg::CNT_W-1:0]     r_node_count;
    logic [tgbfs_pkg::THR_W-1:0]     r_thr;
    logic [CW-1:0]                   r_n, n_n;
    logic [IW-1:0]                   r_root, n_root;
    logic [VW-1:0]                   r_root_val, n_root_val;
    logic [IW-1:0]                   r_comp, n_comp;
    logic [IW-1:0]                   r_pos, n_pos;
    logic [CW-1:0]                   r_head, n_head;
    logic [CW-1:0]                   r_tail, n_tail;
    logic                            r_nf, n_nf;
    logic [IW-1:0]                   r_next, n_next;
    logic [VW-1:0]                   r_next_val, n_next_val;
    logic                            r_pend_v, n_pend_v;
    tgbfs_pkg::t_result              r_pend, n_pend;
    logic                            r_out_v, n_out_v;
    tgbfs_pkg::t_result              r_out, n_out;

    logic [VW-1:0]                   w_val [MAX_NODES];
    logic                            w_vis [MAX_NODES];
    tgbfs_pkg::t_cell_ctrl           cell_ctrl;
    logic                            load_go;
    logic                            mark_go;

    logic                            s_acc;
    logic                            out_free;
    logic                            can_push;
    logic                            push;
    tgbfs_pkg::t_result              push_res;
    logic [5:0]                      in_idx;
    logic [VW-1:0]                   in_val;
    logic [tgbfs_pkg::CNT_W-1:0]     run_n;

    logic [QW-1:0]                   q_rd_data;
    logic [IW-1:0]                   x_node;
    logic [VW-1:0]                   x_val;
    logic                            q_wr_en;
    logic [IW-1:0]                   q_wr_addr;
    logic [QW-1:0]                   q_wr_data;
    logic                            q_rd_en;

    logic [VW:0]                     diff;
    logic [VW:0]                     mag;
    logic                            joined;
    logic                            eligible;
    logic                            hit;
    logic                            cand;
    logic                            last_pos;
    logic [CW-1:0]                   tail_after;

    assign in_idx   = i_s_tdata[5:0];
    assign in_val   = i_s_tdata[21:6];
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_v || i_m_tready;
    assign can_push = !r_pend_v || out_free;
    assign run_n    = (r_node_count > tgbfs_pkg::CNT_W'(MAX_NODES))
                    ? tgbfs_pkg::CNT_W'(MAX_NODES) : r_node_count;

    assign x_node = q_rd_data[QW-1:VW];
    assign x_val  = q_rd_data[VW-1:0];

    // pair test against the value at the head of the ring
    assign diff     = {x_val[VW-1], x_val} - {w_val[0][VW-1], w_val[0]};
    assign mag      = diff[VW] ? (~diff + (VW+1)'(1)) : diff;
    assign joined   = mag[VW-1:0] >= r_thr;
    assign eligible = (r_state == S_SCAN) && (CW'(r_pos) < r_n) && !w_vis[0];
    assign hit      = eligible && joined;
    assign cand     = eligible && !joined;
    assign last_pos = r_pos == IW'(MAX_NODES - 1);

    assign cell_ctrl.shift   = (r_state == S_SCAN) && !(hit && !can_push);
    assign cell_ctrl.clr_vis = s_acc && (i_s_tuser == tgbfs_pkg::ACT_RUN);
    assign load_go = s_acc && (i_s_tuser == tgbfs_pkg::ACT_LOAD)
                   && ({1'b0, in_idx} < tgbfs_pkg::CNT_W'(MAX_NODES));
    assign mark_go = (r_state == S_ROOT) && can_push;

    assign tail_after = r_tail + CW'(hit);

    // ring: cell i takes from cell i+1, the tail cell from the head with the new mark
    for (genvar gi = 0; gi < MAX_NODES; gi++) begin : g_ring
        logic [VW-1:0] nb_val;
        logic          nb_vis;
        if (gi == MAX_NODES - 1) begin : g_wrap
            assign nb_val = w_val[0];
            assign nb_vis = w_vis[0] | hit;
        end else begin : g_mid
            assign nb_val = w_val[gi+1];
            assign nb_vis = w_vis[gi+1];
        end
        tgbfs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl),
            .i_load_en  (load_go && (in_idx == 6'(gi))),
            .i_load_val (in_val),
            .i_mark_en  (mark_go && (r_root == IW'(gi))),
            .i_val      (nb_val),
            .i_vis      (nb_vis),
            .o_val      (w_val[gi]),
            .o_vis      (w_vis[gi])
        );
    end

    assign q_wr_en   = mark_go || (cell_ctrl.shift && hit);
    assign q_wr_addr = (r_state == S_ROOT) ? '0 : r_tail[IW-1:0];
    assign q_wr_data = (r_state == S_ROOT) ? {r_root, r_root_val} : {r_pos, w_val[0]};
    assign q_rd_en   = r_state == S_FETCH;

    tgbfs_queue #(
        .DEPTH  (MAX_NODES),
        .DATA_W (QW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd_en),
        .i_rd_addr (r_head[IW-1:0]),
        .o_rd_data (q_rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_root     = r_root;
        n_root_val = r_root_val;
        n_comp     = r_comp;
        n_pos      = r_pos;
        n_head     = r_head;
        n_tail     = r_tail;
        n_nf       = r_nf;
        n_next     = r_next;
        n_next_val = r_next_val;
        push       = 1'b0;
        push_res   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc && (i_s_tuser == tgbfs_pkg::ACT_RUN)) begin
                    n_n        = CW'(run_n);
                    n_root     = '0;
                    n_root_val = w_val[0];
                    n_comp     = '0;
                    n_pos      = '0;
                    if (run_n != '0) begin
                        n_state = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                if (can_push) begin
                    push             = 1'b1;
                    push_res.node    = NW'(r_root);
                    push_res.parent  = NW'(r_root);
                    push_res.comp    = NW'(r_comp);
                    push_res.is_root = 1'b1;
                    n_head           = '0;
                    n_tail           = CW'(1);
                    n_state          = S_FETCH;
                end
            end
            S_FETCH: begin
                n_head  = r_head + CW'(1);
                n_nf    = 1'b0;
                n_pos   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (cell_ctrl.shift) begin
                    if (hit) begin
                        push            = 1'b1;
                        push_res.node   = NW'(r_pos);
                        push_res.parent = NW'(x_node);
                        push_res.comp   = NW'(r_comp);
                        n_tail          = tail_after;
                    end
                    // lowest node left unvisited by this pass
                    if (cand && !r_nf) begin
                        n_nf       = 1'b1;
                        n_next     = r_pos;
                        n_next_val = w_val[0];
                    end
                    n_pos = last_pos ? '0 : r_pos + IW'(1);
                    if (last_pos) begin
                        if (r_head != tail_after) begin
                            n_state = S_FETCH;
                        end else begin
                            n_comp = r_comp + IW'(1);
                            if (r_nf || cand) begin
                                n_root     = r_nf ? r_next : r_pos;
                                n_root_val = r_nf ? r_next_val : w_val[0];
                                n_state    = S_ROOT;
                            end else begin
                                n_state = S_FLUSH;
                            end
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // pending stage holds the newest result until it is known whether it ends the run
    always_comb begin
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = r_out_v && !i_m_tready;
        n_out    = r_out;
        if (push) begin
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out   = r_pend;
            end
            n_pend_v = 1'b1;
            n_pend   = push_res;
        end else if ((r_state == S_FLUSH) && out_free) begin
            n_out_v    = 1'b1;
            n_out      = r_pend;
            n_out.last = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= tgbfs_pkg::CNT_W'(64);
            r_thr        <= '0;
            r_n          <= '0;
            r_root       <= '0;
            r_comp       <= '0;
            r_pos        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_nf         <= 1'b0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_root   <= n_root;
            r_comp   <= n_comp;
            r_pos    <= n_pos;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_nf     <= n_nf;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                if (i_cfg_addr == tgbfs_pkg::CFG_NODE_COUNT) begin
                    r_node_count <= i_cfg_data[tgbfs_pkg::CNT_W-1:0];
                end else begin
                    r_thr <= i_cfg_data[tgbfs_pkg::THR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_root_val <= n_root_val;
        r_next     <= n_next;
        r_next_val <= n_next_val;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {6'b0, r_out.comp, r_out.parent, r_out.node};
    assign o_m_tuser  = r_out.is_root;
    assign o_m_tlast  = r_out.last;

endmodule

/* rtl/tgbfs_cell.sv */
// one ring cell: a node value and its visited mark, handed to the next cell on shift
// depends on tgbfs_pkg

module tgbfs_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tgbfs_pkg::t_cell_ctrl        i_ctrl,
    input  logic                         i_load_en,
    input  logic [tgbfs_pkg::VAL_W-1:0]  i_load_val,
    input  logic                         i_mark_en,
    input  logic [tgbfs_pkg::VAL_W-1:0]  i_val,
    input  logic                         i_vis,
    output logic [tgbfs_pkg::VAL_W-1:0]  o_val,
    output logic                         o_vis
);

    logic [tgbfs_pkg::VAL_W-1:0] r_val;
    logic                        r_vis;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_val <= i_val;
        end else if (i_load_en) begin
            r_val <= i_load_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis <= 1'b0;
        end else if (i_ctrl.clr_vis) begin
            r_vis <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_vis <= i_vis;
        end else if (i_mark_en) begin
            r_vis <= 1'b1;
        end
    end

    assign o_val = r_val;
    assign o_vis = r_vis;

endmodule

/* rtl/tgbfs_queue.sv */
// bfs queue memory: one write port, one registered read port
// depends on tgbfs_pkg for nothing but house widths passed in as parameters

module tgbfs_queue #(
    parameter int DEPTH  = tgbfs_pkg::MAX_NODES_DEF,
    parameter int DATA_W = tgbfs_pkg::NODE_W + tgbfs_pkg::VAL_W
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
